FILE: rtl/bevq_pkg.sv
// Shared types, constants and helpers for the button event qualifier.
package bevq_pkg;

	// Width of the free-running millisecond counter and all stored times
	localparam int TIME_W = 32;
	// Width used for comparisons against the 32-bit configuration values
	localparam int CMP_W = (TIME_W > 32) ? TIME_W : 32;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT = CFG_IDX_W'(1);

	// Reset values of the configuration registers
	localparam logic [15:0] DEBOUNCE_RST = 16'd50;
	localparam logic [31:0] CLICK_TIMEOUT_RST = 32'd500;

	localparam logic [7:0] CLICKS_MAX = 8'd255;

	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [31:0] click_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic        press_event;
		logic        release_event;
		logic        toggle_state;
		logic [31:0] held_ms;
		logic [31:0] released_after_ms;
		logic [7:0]  click_count;
	} result_t;

	// Low 32 bits of a time value, zero-extended where the counter is narrower
	function automatic logic [31:0] low32(input time_t v);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(v);
		return wide[31:0];
	endfunction

	// Time value widened to the comparison width
	function automatic logic [CMP_W-1:0] widen(input time_t v);
		return CMP_W'(v);
	endfunction

endpackage

FILE: rtl/bevq_core.sv
// Qualifier state and the per-tick update: edges, lockouts, hold time, clicks.
module bevq_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             lvl,
	input  bevq_pkg::cfg_t   cfg,
	output bevq_pkg::result_t res
);
	import bevq_pkg::*;

	time_t      now_q;
	logic       last_level_q;
	time_t      press_acc_q;
	time_t      release_acc_q;
	logic       toggle_q;
	time_t      press_start_q;
	time_t      last_hold_q;
	logic [7:0] clicks_q;
	time_t      last_click_q;

	time_t      t;
	logic       fall;
	logic       rise;
	logic       pev;
	logic       rev;
	time_t      press_start_n;
	time_t      held;
	time_t      last_click_n;
	logic [7:0] clicks_inc;
	logic       timeout_hit;
	logic       toggle_n;

	// Tick update
	always_comb begin
		t    = now_q + time_t'(1);
		fall = last_level_q & ~lvl;
		rise = ~last_level_q & lvl;

		pev = fall && (widen(t - press_acc_q) > CMP_W'(cfg.debounce_ms));
		rev = rise && (widen(t - release_acc_q) > CMP_W'(cfg.debounce_ms));

		press_start_n = fall ? t : press_start_q;
		held          = lvl ? '0 : (t - press_start_n);

		toggle_n     = toggle_q ^ pev;
		last_click_n = pev ? t : last_click_q;
		clicks_inc   = (pev && clicks_q != CLICKS_MAX) ? clicks_q + 8'd1 : clicks_q;
		timeout_hit  = widen(t - last_click_n) >= CMP_W'(cfg.click_timeout_ms);

		res.press_event       = pev;
		res.release_event     = rev;
		res.toggle_state      = toggle_n;
		res.held_ms           = low32(held);
		res.released_after_ms = (held == '0 && last_hold_q != '0) ? low32(last_hold_q) : 32'd0;
		res.click_count       = timeout_hit ? clicks_inc : 8'd0;
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_level_q  <= 1'b1;
			press_acc_q   <= '0;
			release_acc_q <= '0;
			toggle_q      <= 1'b0;
			press_start_q <= '0;
			last_hold_q   <= '0;
			clicks_q      <= '0;
			last_click_q  <= '0;
		end else if (step) begin
			now_q         <= t;
			last_level_q  <= lvl;
			if (pev) press_acc_q <= t;
			if (rev) release_acc_q <= t;
			toggle_q      <= toggle_n;
			press_start_q <= press_start_n;
			last_hold_q   <= held;
			clicks_q      <= timeout_hit ? 8'd0 : clicks_inc;
			last_click_q  <= last_click_n;
		end
	end

endmodule

FILE: rtl/button_event_qualifier.sv
// Top level: input register, configuration registers, qualifier core, result register.
//
// Usage: one request on the input channel per millisecond tick, carrying the
// sampled active-low pin level (0 pressed, 1 released). Every request gives
// exactly one result request with press/release events, toggle bit, held
// time, hold time on release and the click count once the click timeout ends.
// Configuration: cfg_we with cfg_index 0 writes debounce_ms (low 16 bits of
// cfg_data), index 1 writes click_timeout_ms; other indexes are ignored. Write
// only while no request is in flight.
// Data path: an accepted request is registered in the input register, processed by the
// core and loaded into the result register when that is free, which raises out_valid.
// Throughput: one request per cycle while out_ready is high; the input register and the
// result register form a two-stage pipeline, and the core updates its state once per
// tick.
// Reset: the millisecond counter and all stored times clear, the last level
// reads released, debounce_ms is 50 and click_timeout_ms is 500.
// Stall: while out_ready is low the result holds; one further request is taken
// into the input register, after which in_ready drops until the result goes.
module button_event_qualifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                pin_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                press_event,
	output logic                                release_event,
	output logic                                toggle_state,
	output logic [31:0]                         held_ms,
	output logic [31:0]                         released_after_ms,
	output logic [7:0]                          click_count,
	input  logic                                cfg_we,
	input  logic [bevq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bevq_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bevq_pkg::*;

	cfg_t    cfg_q;
	logic    v_s1;
	logic    lvl_s1;
	logic    v_s2;
	result_t res_s2;
	result_t res_core;
	logic    advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.click_timeout_ms <= CLICK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:      cfg_q.debounce_ms <= cfg_data[15:0];
				CFG_CLICK_TIMEOUT: cfg_q.click_timeout_ms <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves into the result register when that is free
	assign advance  = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) lvl_s1 <= pin_level;
	end

	bevq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.lvl    (lvl_s1),
		.cfg    (cfg_q),
		.res    (res_core)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_core;
	end

	assign out_valid         = v_s2;
	assign press_event       = res_s2.press_event;
	assign release_event     = res_s2.release_event;
	assign toggle_state      = res_s2.toggle_state;
	assign held_ms           = res_s2.held_ms;
	assign released_after_ms = res_s2.released_after_ms;
	assign click_count       = res_s2.click_count;

endmodule
